FILE: design/json_string_escaper_top_defines.svh
// Assertion helpers for the escaper top-level RTL.
`ifndef JSON_STRING_ESCAPER_TOP_DEFINES_SVH
`define JSON_STRING_ESCAPER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define JSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: design/jse_pkg.sv
`default_nettype none

package jse_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SeqMax  = 6;
  localparam int unsigned SeqCntW = 3;
  localparam int unsigned CapW    = 16;
  localparam int unsigned PosW    = 16;

  localparam int unsigned LengthBitsDefault = 16;
  localparam logic [CapW-1:0] CapReset = 16'd4096;

  localparam logic CmdAppend  = 1'b0;
  localparam logic CmdRestart = 1'b1;

  localparam logic [ByteW-1:0] ChQuote     = 8'h22;
  localparam logic [ByteW-1:0] ChBackslash = 8'h5c;
  localparam logic [ByteW-1:0] ChBackspace = 8'h08;
  localparam logic [ByteW-1:0] ChFormFeed  = 8'h0c;
  localparam logic [ByteW-1:0] ChNewline   = 8'h0a;
  localparam logic [ByteW-1:0] ChReturn    = 8'h0d;
  localparam logic [ByteW-1:0] ChTab       = 8'h09;
  localparam logic [ByteW-1:0] ChDelete    = 8'h7f;
  localparam logic [ByteW-1:0] CtrlLimit   = 8'h20;
  localparam logic [ByteW-1:0] LetterB     = 8'h62;
  localparam logic [ByteW-1:0] LetterF     = 8'h66;
  localparam logic [ByteW-1:0] LetterN     = 8'h6e;
  localparam logic [ByteW-1:0] LetterR     = 8'h72;
  localparam logic [ByteW-1:0] LetterT     = 8'h74;
  localparam logic [ByteW-1:0] LetterU     = 8'h75;
  localparam logic [ByteW-1:0] Digit0      = 8'h30;
  localparam logic [ByteW-1:0] HexAlphaOff = 8'h57;

  // Escape sequence for one input item; byte 0 is emitted first.
  typedef struct packed {
    logic                           restart;
    logic [SeqCntW-1:0]             count;
    logic [SeqMax-1:0][ByteW-1:0]   bytes;
  } seq_t;

  function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] v);
    logic [ByteW-1:0] ext;
    ext = {4'h0, v};
    if (v < 4'd10) begin
      return ext + Digit0;
    end else begin
      return ext + HexAlphaOff;
    end
  endfunction

endpackage

`default_nettype wire

FILE: design/jse_encoder.sv
`default_nettype none

module jse_encoder (
  input  logic                   cmd_i,
  input  logic [7:0]             in_byte_i,
  output jse_pkg::seq_t          seq_o
);
  import jse_pkg::*;

  always_comb begin
    seq_o          = '0;
    seq_o.count    = SeqCntW'(1);
    seq_o.bytes[0] = in_byte_i;
    if (cmd_i == CmdRestart) begin
      seq_o.restart  = 1'b1;
      seq_o.bytes[0] = '0;
    end else begin
      case (in_byte_i)
        ChQuote, ChBackslash: begin
          seq_o.count    = SeqCntW'(2);
          seq_o.bytes[0] = ChBackslash;
          seq_o.bytes[1] = in_byte_i;
        end
        ChBackspace: begin
          seq_o.count    = SeqCntW'(2);
          seq_o.bytes[0] = ChBackslash;
          seq_o.bytes[1] = LetterB;
        end
        ChFormFeed: begin
          seq_o.count    = SeqCntW'(2);
          seq_o.bytes[0] = ChBackslash;
          seq_o.bytes[1] = LetterF;
        end
        ChNewline: begin
          seq_o.count    = SeqCntW'(2);
          seq_o.bytes[0] = ChBackslash;
          seq_o.bytes[1] = LetterN;
        end
        ChReturn: begin
          seq_o.count    = SeqCntW'(2);
          seq_o.bytes[0] = ChBackslash;
          seq_o.bytes[1] = LetterR;
        end
        ChTab: begin
          seq_o.count    = SeqCntW'(2);
          seq_o.bytes[0] = ChBackslash;
          seq_o.bytes[1] = LetterT;
        end
        default: begin
          // Remaining control bytes and delete use the six-byte unicode form.
          if (in_byte_i < CtrlLimit || in_byte_i == ChDelete) begin
            seq_o.count    = SeqCntW'(SeqMax);
            seq_o.bytes[0] = ChBackslash;
            seq_o.bytes[1] = LetterU;
            seq_o.bytes[2] = Digit0;
            seq_o.bytes[3] = Digit0;
            seq_o.bytes[4] = hex_digit(in_byte_i[7:4]);
            seq_o.bytes[5] = hex_digit(in_byte_i[3:0]);
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/json_string_escaper_top.sv
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o | cmd_i, in_byte_i
//  out     | output    | out_valid_o/out_stall_i | out_byte_o, position_o, stored_o,
//          |           |                         | truncated_o, last_o
//  cfg     | input     | cfg_we_i                | cfg_wdata_i (buffer capacity)
//
// A plain byte or a restart yields one output byte, a two-byte escape two and a unicode escape
// six: the sequence register hands one byte per cycle to the result register while that is not stalled.
// The next transaction is taken in the cycle that the final byte of the current one moves on.
// Reset clears the fill length, the truncation flag and all valid bits; capacity becomes 4096.
// A stall on the output holds the result register and, once the sequence register is busy,
// stalls the input as well.
`default_nettype none

module json_string_escaper_top #(
  parameter int unsigned LengthBits = jse_pkg::LengthBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [jse_pkg::CapW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [7:0]                  in_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  out_byte_o,
  output logic [jse_pkg::PosW-1:0]    position_o,
  output logic                        stored_o,
  output logic                        truncated_o,
  output logic                        last_o
);
  import jse_pkg::*;
  `include "json_string_escaper_top_defines.svh"

  localparam int unsigned LimW = (LengthBits > CapW) ? LengthBits : CapW;

  logic [CapW-1:0]              cap_q;
  logic [LengthBits-1:0]        fill_q, fill_d;
  logic                         trunc_q, trunc_d;

  seq_t                         enc_seq;
  logic                         seq_valid_q, seq_valid_d;
  logic                         seq_restart_q, seq_restart_d;
  logic [SeqCntW-1:0]           seq_left_q, seq_left_d;
  logic [SeqMax-1:0][ByteW-1:0] seq_bytes_q, seq_bytes_d;

  logic                         out_valid_q, out_valid_d;
  logic [ByteW-1:0]             out_byte_q, out_byte_d;
  logic [PosW-1:0]              pos_q, pos_d;
  logic                         stored_q, stored_d;
  logic                         trunc_out_q, trunc_out_d;
  logic                         last_q, last_d;

  logic                         out_free;
  logic                         emit;
  logic                         emit_last;
  logic                         in_accept;
  logic [LimW-1:0]              limit;
  logic [LimW-1:0]              cnt_max;
  logic [LimW-1:0]              fill_ext;

  jse_encoder u_encoder (
    .cmd_i     (cmd_i),
    .in_byte_i (in_byte_i),
    .seq_o     (enc_seq)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = seq_valid_q && out_free;
  assign emit_last  = seq_left_q == SeqCntW'(1);
  assign in_stall_o = seq_valid_q && !(emit && emit_last);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Store limit is capacity minus one, capped by what the fill counter can hold.
  always_comb begin
    cnt_max                 = '0;
    cnt_max[LengthBits-1:0] = '1;
    fill_ext                = LimW'(fill_q);
    if (cap_q == '0) begin
      limit = '0;
    end else begin
      limit = LimW'(cap_q) - LimW'(1);
      if (limit > cnt_max) begin
        limit = cnt_max;
      end
    end
  end

  always_comb begin
    seq_valid_d   = seq_valid_q;
    seq_restart_d = seq_restart_q;
    seq_left_d    = seq_left_q;
    seq_bytes_d   = seq_bytes_q;
    if (emit) begin
      seq_left_d  = seq_left_q - SeqCntW'(1);
      seq_bytes_d = seq_bytes_q >> ByteW;
      if (emit_last) begin
        seq_valid_d = 1'b0;
      end
    end
    if (in_accept) begin
      seq_valid_d   = 1'b1;
      seq_restart_d = enc_seq.restart;
      seq_left_d    = enc_seq.count;
      seq_bytes_d   = enc_seq.bytes;
    end
  end

  always_comb begin
    fill_d      = fill_q;
    trunc_d     = trunc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    pos_d       = pos_q;
    stored_d    = stored_q;
    trunc_out_d = trunc_out_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = seq_bytes_q[0];
      last_d      = emit_last;
      stored_d    = 1'b0;
      pos_d       = fill_ext[PosW-1:0];
      if (seq_restart_q) begin
        fill_d  = '0;
        trunc_d = 1'b0;
        pos_d   = '0;
      end else if (fill_ext < limit) begin
        fill_d   = fill_q + LengthBits'(1);
        stored_d = 1'b1;
      end else begin
        trunc_d = 1'b1;
      end
      trunc_out_d = trunc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      fill_q      <= '0;
      trunc_q     <= 1'b0;
      seq_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      fill_q      <= fill_d;
      trunc_q     <= trunc_d;
      seq_valid_q <= seq_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_restart_q <= seq_restart_d;
    seq_left_q    <= seq_left_d;
    seq_bytes_q   <= seq_bytes_d;
    out_byte_q    <= out_byte_d;
    pos_q         <= pos_d;
    stored_q      <= stored_d;
    trunc_out_q   <= trunc_out_d;
    last_q        <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign position_o  = pos_q;
  assign stored_o    = stored_q;
  assign truncated_o = trunc_out_q;
  assign last_o      = last_q;

  // A zero byte on the output can only be the restart transaction.
  `JSE_ASSERT_IMPL(a_restart_result, clk_i, rst_ni, out_valid_o && out_byte_o == '0, !stored_o && !truncated_o && last_o && position_o == '0)
  `JSE_ASSERT_IMPL(a_seq_count_range, clk_i, rst_ni, seq_valid_q, seq_left_q != '0 && seq_left_q <= SeqCntW'(SeqMax))
  `JSE_ASSERT_NEXT(a_fill_advances, clk_i, rst_ni, emit && stored_d, fill_q == $past(fill_q) + LengthBits'(1))

endmodule

`default_nettype wire
